// File: hdl/bcc_pkg.sv
package bcc_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LEVEL         = 3'd0,
        CFG_NO_BATTERY_LEVEL  = 3'd1,
        CFG_FULL_LEVEL        = 3'd2,
        CFG_USER_CURRENT_CODE = 3'd3,
        CFG_TOPUP_LIMIT       = 3'd4,
        CFG_MIN_CURRENT_LIMIT = 3'd5
    } t_cfg_idx;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_CHECK  = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_STOP   = 2'd2,
        FUNC_STATUS = 2'd3
    } t_func;

    // Reported charge status
    typedef enum logic [1:0] {
        STATUS_IDLE     = 2'd0,
        STATUS_CHARGING = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_UNUSED   = 2'd3
    } t_status;

    // Register reset values
    localparam logic [7:0] RST_LOW_LEVEL         = 8'h44;
    localparam logic [7:0] RST_NO_BATTERY_LEVEL  = 8'h5d;
    localparam logic [7:0] RST_FULL_LEVEL        = 8'h75;
    localparam logic [3:0] RST_USER_CURRENT_CODE = 4'h3;
    localparam logic [4:0] RST_TOPUP_LIMIT       = 5'd20;
    localparam logic [2:0] RST_MIN_CURRENT_LIMIT = 3'd3;

    // Current codes: probe current is 50 mA, code 1 is the floor of the step-down
    localparam logic [2:0] PROBE_CURRENT_LOW = 3'b010;
    localparam logic [3:0] MIN_CURRENT_CODE  = 4'h1;

    typedef struct packed {
        logic [7:0] low_level;
        logic [7:0] no_battery_level;
        logic [7:0] full_level;
        logic [3:0] user_current_code;
        logic [4:0] topup_limit;
        logic [2:0] min_current_limit;
    } t_cfg;

    typedef struct packed {
        logic       charging;
        logic       full_flag;
        logic       current_loaded;
        logic [2:0] min_current_count;
        logic [4:0] topup_count;
        logic       unplugged;
        logic       enable_reg;
        logic [3:0] current_reg;
        logic       trickle_reg;
    } t_state;

    typedef struct packed {
        t_func      func;
        logic       usb_present;
        logic [7:0] battery_level;
        logic [7:0] settled_level;
        logic       supply_ok;
    } t_in_item;

    typedef struct packed {
        t_status    charge_status;
        logic       charge_enable;
        logic [3:0] current_code;
        logic       trickle_off;
    } t_out_item;

    // Stop action: drop enable, charging, loaded current and min-current count
    function automatic t_state halt_charge(input t_state s);
        t_state h;
        h                   = s;
        h.enable_reg        = 1'b0;
        h.charging          = 1'b0;
        h.current_loaded    = 1'b0;
        h.min_current_count = 3'd0;
        return h;
    endfunction

endpackage

// File: hdl/bcc_in_if.sv
interface bcc_in_if;
    import bcc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/bcc_out_if.sv
interface bcc_out_if;
    import bcc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/bcc_cfg.sv
module bcc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output bcc_pkg::t_cfg                    o_cfg
);
    import bcc_pkg::*;

    t_cfg r_cfg;

    // Load reset values, then take writes by index; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_level         <= RST_LOW_LEVEL;
            r_cfg.no_battery_level  <= RST_NO_BATTERY_LEVEL;
            r_cfg.full_level        <= RST_FULL_LEVEL;
            r_cfg.user_current_code <= RST_USER_CURRENT_CODE;
            r_cfg.topup_limit       <= RST_TOPUP_LIMIT;
            r_cfg.min_current_limit <= RST_MIN_CURRENT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOW_LEVEL:         r_cfg.low_level         <= i_cfg_data;
                CFG_NO_BATTERY_LEVEL:  r_cfg.no_battery_level  <= i_cfg_data;
                CFG_FULL_LEVEL:        r_cfg.full_level        <= i_cfg_data;
                CFG_USER_CURRENT_CODE: r_cfg.user_current_code <= i_cfg_data[3:0];
                CFG_TOPUP_LIMIT:       r_cfg.topup_limit       <= i_cfg_data[4:0];
                CFG_MIN_CURRENT_LIMIT: r_cfg.min_current_limit <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/bcc_update.sv
module bcc_update (
    input  bcc_pkg::t_state    i_state,
    input  bcc_pkg::t_cfg      i_cfg,
    input  bcc_pkg::t_in_item  i_item,
    output bcc_pkg::t_state    o_state,
    output bcc_pkg::t_out_item o_result
);
    import bcc_pkg::*;

    t_state     n_state;
    logic [3:0] min_next;

    assign min_next = {1'b0, i_state.min_current_count} + 4'd1;

    // Work out the state after one request
    always_comb begin
        n_state = i_state;
        case (i_item.func)
            FUNC_CHECK: begin
                if (!i_item.usb_present) begin
                    // first absent tick stops, later ones only hold
                    if (!i_state.unplugged) n_state = halt_charge(i_state);
                    n_state.unplugged = 1'b1;
                end else if (!i_state.charging) begin
                    n_state           = halt_charge(i_state);
                    n_state.unplugged = 1'b0;
                end else if (i_item.battery_level < i_cfg.low_level) begin
                    // probe a deeply discharged battery at low current
                    n_state.unplugged   = 1'b0;
                    n_state.current_reg = {i_state.current_reg[3], PROBE_CURRENT_LOW};
                    n_state.trickle_reg = 1'b1;
                    n_state.enable_reg  = 1'b1;
                    if (i_item.settled_level >= i_cfg.no_battery_level)
                        n_state = halt_charge(n_state);
                end else if (!i_state.current_loaded) begin
                    n_state.unplugged = 1'b0;
                    if (i_item.battery_level < i_cfg.full_level) begin
                        n_state.trickle_reg    = 1'b1;
                        n_state.enable_reg     = 1'b1;
                        n_state.current_reg    = i_cfg.user_current_code;
                        n_state.current_loaded = 1'b1;
                    end else begin
                        n_state           = halt_charge(n_state);
                        n_state.full_flag = 1'b1;
                    end
                end else begin
                    n_state.unplugged = 1'b0;
                    if (!i_item.supply_ok && (i_state.current_reg <= MIN_CURRENT_CODE) &&
                        (min_next > {1'b0, i_cfg.min_current_limit})) begin
                        // weak supply at minimum current for too long
                        n_state           = halt_charge(n_state);
                        n_state.full_flag = 1'b1;
                    end else begin
                        // step the current down on a weak supply
                        if (!i_item.supply_ok) begin
                            if (i_state.current_reg > MIN_CURRENT_CODE) begin
                                n_state.min_current_count = 3'd0;
                                n_state.current_reg       = i_state.current_reg - 4'd1;
                            end else begin
                                n_state.min_current_count = min_next[2:0];
                            end
                        end
                        // top up above the full level, then confirm on the settled read
                        if (i_item.battery_level > i_cfg.full_level) begin
                            if (i_state.topup_count < i_cfg.topup_limit) begin
                                n_state.topup_count = i_state.topup_count + 5'd1;
                            end else if (i_item.settled_level > i_cfg.full_level) begin
                                n_state           = halt_charge(n_state);
                                n_state.full_flag = 1'b1;
                            end else begin
                                n_state.enable_reg  = 1'b1;
                                n_state.topup_count = 5'd0;
                            end
                        end
                    end
                end
            end
            FUNC_START:  n_state.charging = 1'b1;
            FUNC_STOP:   n_state.charging = 1'b0;
            default: ;
        endcase
    end

    // Report status and charger drive after the update
    always_comb begin
        if (n_state.charging)       o_result.charge_status = STATUS_CHARGING;
        else if (n_state.full_flag) o_result.charge_status = STATUS_FULL;
        else                        o_result.charge_status = STATUS_IDLE;
        o_result.charge_enable = n_state.enable_reg;
        o_result.current_code  = n_state.current_reg;
        o_result.trickle_off   = n_state.trickle_reg;
    end

    assign o_state = n_state;

endmodule

// File: hdl/battery_charge_controller_top.sv
// Battery charge sequencer: every request (check tick, start, stop or status
// query) returns exactly one result with the charge status and the charger
// drive as they stand after that request. A request is held in the input
// register and its result is captured in the output register when it moves
// on; a new request is taken every cycle while results are taken, set by
// the combinational state update between the two registers, and the input
// keeps accepting while a result waits as long as the input register can
// move on. The user writes thresholds and limits through the configuration
// port only while no request is in flight; the block does not enforce this.
module battery_charge_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bcc_in_if.sink                         i_req,
    bcc_out_if.source                      o_rsp
);
    import bcc_pkg::*;

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_result;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;

    bcc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bcc_update u_update (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Move a request forward when the result register is free or being taken
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) r_in_item <= i_req.data;
    end

    // Sequencer state advances once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_out_item <= n_result;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_item;

endmodule

// File: hdl/bcc_checker.sv
module bcc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input bcc_pkg::t_out_item  i_out_data
);
    import bcc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed or dropped while stalled");

    // A fresh result follows a request taken through the input and result registers
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a request");

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Never report the unused status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.charge_status != STATUS_UNUSED)
        else $error("unused charge status reported");

endmodule

bind battery_charge_controller_top bcc_checker u_bcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);
